// File: design/fractional_clock_ratio_converter_assert.svh
// Assertion macros for the fractional clock ratio converter.
// Included by the top level; depends on nothing else.
`ifndef FRACTIONAL_CLOCK_RATIO_CONVERTER_ASSERT_SVH
`define FRACTIONAL_CLOCK_RATIO_CONVERTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FRCC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FRCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/frcc_pkg.sv
// Shared constants and types of the fractional clock ratio converter.
// No dependencies; used by every other design file but the assertion header.
`default_nettype none

package frcc_pkg;

    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [KIND_W-1:0] KIND_ADVANCE = KIND_W'(0);
    localparam logic [KIND_W-1:0] KIND_QUERY   = KIND_W'(1);
    localparam logic [KIND_W-1:0] KIND_RESET   = KIND_W'(2);

    localparam logic [STATUS_W-1:0] STATUS_OK      = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] STATUS_BAD_ARG = STATUS_W'(1);

    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_NUMERATOR   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_DENOMINATOR = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_START_PHASE       = CFG_IDX_W'(2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_AMT,
        S_MUL_WHOLE,
        S_MUL_REM,
        S_DIV_REM,
        S_MUL_REQ,
        S_DIV_REQ,
        S_FINISH
    } frcc_state_t;

    typedef enum logic [2:0] {
        ARITH_HOLD,
        ARITH_LOAD_DIV,
        ARITH_LOAD_MUL,
        ARITH_DIV_STEP,
        ARITH_MUL_STEP
    } arith_cmd_t;

endpackage

`default_nettype wire

// File: design/frcc_channels.sv
// Handshake channels of the converter: configuration writes, items and results.
// Depends on frcc_pkg for the code widths.
`default_nettype none

interface frcc_cfg_if #(parameter int RATIO_WIDTH = 32);
    logic                            valid;
    logic                            ready;
    logic [frcc_pkg::CFG_IDX_W-1:0]  index;
    logic [RATIO_WIDTH-1:0]          data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

interface frcc_item_if #(parameter int COUNT_WIDTH = 64);
    logic                         valid;
    logic                         ready;
    logic [frcc_pkg::KIND_W-1:0]  kind;
    logic [COUNT_WIDTH-1:0]       amount;
    modport source (output valid, output kind, output amount, input ready);
    modport sink (input valid, input kind, input amount, output ready);
endinterface

interface frcc_result_if #(parameter int COUNT_WIDTH = 64);
    logic                           valid;
    logic                           ready;
    logic [COUNT_WIDTH-1:0]         converted_ticks;
    logic [COUNT_WIDTH-1:0]         source_ticks_needed;
    logic [COUNT_WIDTH-1:0]         total_delivered;
    logic [frcc_pkg::STATUS_W-1:0]  status;
    modport source (output valid, output converted_ticks, output source_ticks_needed,
                    output total_delivered, output status, input ready);
    modport sink (input valid, input converted_ticks, input source_ticks_needed,
                  input total_delivered, input status, output ready);
endinterface

`default_nettype wire

// File: design/fractional_clock_ratio_converter.sv
// Fractional clock ratio converter top level: phase accumulator and sequencer.
// Depends on frcc_pkg, the channel interfaces, frcc_arith and the assertion header.
// The block handles one item at a time through a shared arithmetic unit that
// retires one bit per cycle. An advance with numerator different from denominator
// runs one division of the amount, two multiplications and one short division of
// the remainder before its result. A query runs one multiplication and one division,
// or only the multiplication when it overflows or falls within the current phase.
// A reset item, an advance at equal ratio and any rejected item go straight from
// accept to the finish state. The next item is accepted only after a result is
// loaded. A finished result waits in an output register, so the next item is
// taken while the previous result has not yet been collected. Configuration writes
// are taken whenever no item is in progress and have priority over a new item.
`default_nettype none

`include "fractional_clock_ratio_converter_assert.svh"

module fractional_clock_ratio_converter #(
    parameter int COUNT_WIDTH = 64,
    parameter int RATIO_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    frcc_cfg_if.sink      cfg,
    frcc_item_if.sink     item,
    frcc_result_if.source result
);
    import frcc_pkg::*;

    localparam int MW       = (COUNT_WIDTH > RATIO_WIDTH) ? COUNT_WIDTH : RATIO_WIDTH;
    localparam int PW       = MW + RATIO_WIDTH;
    localparam int CNT_W    = $clog2(MW + 1);
    localparam int ALIGN_CW = MW - COUNT_WIDTH;
    localparam int ALIGN_RW = MW - RATIO_WIDTH;
    localparam logic [CNT_W-1:0] CW_STEPS = CNT_W'(COUNT_WIDTH);
    localparam logic [CNT_W-1:0] RW_STEPS = CNT_W'(RATIO_WIDTH);

    frcc_state_t state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;

    logic [RATIO_WIDTH-1:0] num_raw_reg, num_raw_next;
    logic [RATIO_WIDTH-1:0] den_raw_reg, den_raw_next;
    logic [RATIO_WIDTH-1:0] phs_raw_reg, phs_raw_next;
    logic [RATIO_WIDTH-1:0] eff_num_reg, eff_num_next;
    logic [RATIO_WIDTH-1:0] eff_den_reg, eff_den_next;
    logic [RATIO_WIDTH-1:0] eff_ph_reg, eff_ph_next;
    logic                   cfg_ok_reg, cfg_ok_next;
    logic                   unity_reg, unity_next;

    logic [RATIO_WIDTH-1:0] phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] total_reg, total_next;

    logic [COUNT_WIDTH-1:0] whole_reg, whole_next;
    logic [COUNT_WIDTH-1:0] res_conv_reg, res_conv_next;
    logic [COUNT_WIDTH-1:0] res_need_reg, res_need_next;
    logic [STATUS_W-1:0]    res_status_reg, res_status_next;

    logic                   out_valid_reg, out_valid_next;
    logic [COUNT_WIDTH-1:0] out_conv_reg, out_conv_next;
    logic [COUNT_WIDTH-1:0] out_need_reg, out_need_next;
    logic [COUNT_WIDTH-1:0] out_total_reg, out_total_next;
    logic [STATUS_W-1:0]    out_status_reg, out_status_next;

    arith_cmd_t             arith_cmd;
    logic [RATIO_WIDTH-1:0] divisor;
    logic [MW-1:0]          ld_word;
    logic [MW-1:0]          ld_upper;
    logic [RATIO_WIDTH-1:0] ld_mplier;
    logic [MW-1:0]          quotient;
    logic [RATIO_WIDTH-1:0] remainder;
    logic [PW-1:0]          product;

    logic                   item_acc;
    logic                   cfg_hit;
    logic [RATIO_WIDTH-1:0] w_num;
    logic [RATIO_WIDTH-1:0] w_den;
    logic [RATIO_WIDTH-1:0] w_phs;
    logic                   w_ident;
    logic                   w_ok;
    logic                   cnt_done;
    logic [CNT_W-1:0]       cnt_dec;
    logic [MW-1:0]          phase_w;
    logic [MW-1:0]          req_w;
    logic                   req_ovf;
    logic [COUNT_WIDTH-1:0] conv_sum;

    frcc_arith #(
        .WORD_WIDTH  (MW),
        .RATIO_WIDTH (RATIO_WIDTH)
    ) u_arith (
        .clk       (clk),
        .cmd       (arith_cmd),
        .divisor   (divisor),
        .ld_word   (ld_word),
        .ld_upper  (ld_upper),
        .ld_mplier (ld_mplier),
        .quotient  (quotient),
        .remainder (remainder),
        .product   (product)
    );

    assign cfg.ready    = (state_reg == S_IDLE);
    assign item.ready   = (state_reg == S_IDLE) && !cfg.valid;
    assign item_acc     = item.valid && item.ready;
    assign cfg_hit      = cfg.valid && cfg.ready && (cfg.index inside
                          {CFG_RATIO_NUMERATOR, CFG_RATIO_DENOMINATOR, CFG_START_PHASE});

    assign w_num   = (cfg.index == CFG_RATIO_NUMERATOR) ? cfg.data : num_raw_reg;
    assign w_den   = (cfg.index == CFG_RATIO_DENOMINATOR) ? cfg.data : den_raw_reg;
    assign w_phs   = (cfg.index == CFG_START_PHASE) ? cfg.data : phs_raw_reg;
    assign w_ident = (w_num == '0) && (w_den == '0) && (w_phs == '0);
    assign w_ok    = w_ident || ((w_num != '0) && (w_den != '0) && (w_phs < w_den));

    assign cnt_done = (cnt_reg == '0);
    assign cnt_dec  = cnt_reg - CNT_W'(1);
    assign phase_w  = MW'(phase_reg);
    assign req_w    = MW'(product[COUNT_WIDTH-1:0]);
    assign req_ovf  = |product[PW-1:COUNT_WIDTH];
    assign conv_sum = whole_reg + COUNT_WIDTH'(quotient[RATIO_WIDTH-1:0]);

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        num_raw_next    = num_raw_reg;
        den_raw_next    = den_raw_reg;
        phs_raw_next    = phs_raw_reg;
        eff_num_next    = eff_num_reg;
        eff_den_next    = eff_den_reg;
        eff_ph_next     = eff_ph_reg;
        cfg_ok_next     = cfg_ok_reg;
        unity_next      = unity_reg;
        phase_next      = phase_reg;
        total_next      = total_reg;
        whole_next      = whole_reg;
        res_conv_next   = res_conv_reg;
        res_need_next   = res_need_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_conv_next   = out_conv_reg;
        out_need_next   = out_need_reg;
        out_total_next  = out_total_reg;
        out_status_next = out_status_reg;
        arith_cmd       = ARITH_HOLD;
        divisor         = eff_den_reg;
        ld_word         = '0;
        ld_upper        = '0;
        ld_mplier       = '0;

        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item_acc)
                begin
                    state_next      = S_FINISH;
                    res_conv_next   = '0;
                    res_need_next   = '0;
                    res_status_next = STATUS_BAD_ARG;
                    if (cfg_ok_reg)
                    begin
                        case (item.kind)
                            KIND_ADVANCE:
                            begin
                                res_status_next = STATUS_OK;
                                if (unity_reg)
                                begin
                                    res_conv_next = item.amount;
                                    total_next    = total_reg + item.amount;
                                end
                                else
                                begin
                                    arith_cmd  = ARITH_LOAD_DIV;
                                    ld_word    = MW'(item.amount) << ALIGN_CW;
                                    cnt_next   = CW_STEPS;
                                    state_next = S_DIV_AMT;
                                end
                            end
                            KIND_QUERY:
                            begin
                                if (item.amount != '0)
                                begin
                                    arith_cmd  = ARITH_LOAD_MUL;
                                    ld_word    = MW'(item.amount);
                                    ld_mplier  = eff_den_reg;
                                    cnt_next   = RW_STEPS;
                                    state_next = S_MUL_REQ;
                                end
                            end
                            KIND_RESET:
                            begin
                                res_status_next = STATUS_OK;
                                phase_next      = eff_ph_reg;
                                total_next      = '0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            S_DIV_AMT:
            begin
                if (!cnt_done)
                begin
                    arith_cmd = ARITH_DIV_STEP;
                    cnt_next  = cnt_dec;
                end
                else
                begin
                    arith_cmd  = ARITH_LOAD_MUL;
                    ld_word    = quotient;
                    ld_mplier  = eff_num_reg;
                    cnt_next   = RW_STEPS;
                    state_next = S_MUL_WHOLE;
                end
            end
            S_MUL_WHOLE:
            begin
                if (!cnt_done)
                begin
                    arith_cmd = ARITH_MUL_STEP;
                    cnt_next  = cnt_dec;
                end
                else
                begin
                    whole_next = product[COUNT_WIDTH-1:0];
                    arith_cmd  = ARITH_LOAD_MUL;
                    ld_word    = MW'(remainder);
                    ld_upper   = phase_w;
                    ld_mplier  = eff_num_reg;
                    cnt_next   = RW_STEPS;
                    state_next = S_MUL_REM;
                end
            end
            S_MUL_REM:
            begin
                if (!cnt_done)
                begin
                    arith_cmd = ARITH_MUL_STEP;
                    cnt_next  = cnt_dec;
                end
                else
                begin
                    // The upper half of the remainder is already below the denominator,
                    // so only the lower half needs division steps.
                    arith_cmd  = ARITH_LOAD_DIV;
                    ld_upper   = MW'(product[2*RATIO_WIDTH-1:RATIO_WIDTH]);
                    ld_word    = MW'(product[RATIO_WIDTH-1:0]) << ALIGN_RW;
                    cnt_next   = RW_STEPS;
                    state_next = S_DIV_REM;
                end
            end
            S_DIV_REM:
            begin
                if (!cnt_done)
                begin
                    arith_cmd = ARITH_DIV_STEP;
                    cnt_next  = cnt_dec;
                end
                else
                begin
                    res_conv_next   = conv_sum;
                    res_need_next   = '0;
                    res_status_next = STATUS_OK;
                    phase_next      = remainder;
                    total_next      = total_reg + conv_sum;
                    state_next      = S_FINISH;
                end
            end
            S_MUL_REQ:
            begin
                if (!cnt_done)
                begin
                    arith_cmd = ARITH_MUL_STEP;
                    cnt_next  = cnt_dec;
                end
                else if (req_ovf)
                begin
                    res_conv_next   = '0;
                    res_need_next   = '0;
                    res_status_next = STATUS_BAD_ARG;
                    state_next      = S_FINISH;
                end
                else if (req_w <= phase_w)
                begin
                    res_conv_next   = '0;
                    res_need_next   = COUNT_WIDTH'(1);
                    res_status_next = STATUS_OK;
                    state_next      = S_FINISH;
                end
                else
                begin
                    arith_cmd  = ARITH_LOAD_DIV;
                    divisor    = eff_num_reg;
                    ld_word    = (req_w - phase_w) << ALIGN_CW;
                    cnt_next   = CW_STEPS;
                    state_next = S_DIV_REQ;
                end
            end
            S_DIV_REQ:
            begin
                divisor = eff_num_reg;
                if (!cnt_done)
                begin
                    arith_cmd = ARITH_DIV_STEP;
                    cnt_next  = cnt_dec;
                end
                else
                begin
                    res_conv_next   = '0;
                    res_need_next   = quotient[COUNT_WIDTH-1:0]
                                      + COUNT_WIDTH'(remainder != '0);
                    res_status_next = STATUS_OK;
                    state_next      = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_conv_next   = res_conv_reg;
                    out_need_next   = res_need_reg;
                    out_total_next  = total_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A configuration write restarts the phase and the running total.
        if (cfg_hit)
        begin
            num_raw_next = w_num;
            den_raw_next = w_den;
            phs_raw_next = w_phs;
            eff_num_next = w_ident ? RATIO_WIDTH'(1) : w_num;
            eff_den_next = w_ident ? RATIO_WIDTH'(1) : w_den;
            eff_ph_next  = w_ident ? '0 : w_phs;
            cfg_ok_next  = w_ok;
            unity_next   = w_ident || (w_num == w_den);
            phase_next   = (w_ok && !w_ident) ? w_phs : '0;
            total_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            num_raw_reg   <= '0;
            den_raw_reg   <= '0;
            phs_raw_reg   <= '0;
            eff_num_reg   <= RATIO_WIDTH'(1);
            eff_den_reg   <= RATIO_WIDTH'(1);
            eff_ph_reg    <= '0;
            cfg_ok_reg    <= 1'b1;
            unity_reg     <= 1'b1;
            phase_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            num_raw_reg   <= num_raw_next;
            den_raw_reg   <= den_raw_next;
            phs_raw_reg   <= phs_raw_next;
            eff_num_reg   <= eff_num_next;
            eff_den_reg   <= eff_den_next;
            eff_ph_reg    <= eff_ph_next;
            cfg_ok_reg    <= cfg_ok_next;
            unity_reg     <= unity_next;
            phase_reg     <= phase_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        whole_next_stage: begin
            whole_reg      <= whole_next;
            res_conv_reg   <= res_conv_next;
            res_need_reg   <= res_need_next;
            res_status_reg <= res_status_next;
            out_conv_reg   <= out_conv_next;
            out_need_reg   <= out_need_next;
            out_total_reg  <= out_total_next;
            out_status_reg <= out_status_next;
        end
    end

    assign result.valid               = out_valid_reg;
    assign result.converted_ticks     = out_conv_reg;
    assign result.source_ticks_needed = out_need_reg;
    assign result.total_delivered     = out_total_reg;
    assign result.status              = out_status_reg;

    `FRCC_ASSERT_IMPLY(a_beat_from_finish, clk, rst_n, $rose(out_valid_reg), $past(state_reg) == S_FINISH, "result beat raised outside the finish state")
    `FRCC_ASSERT_IMPLY(a_phase_below_den, clk, rst_n, (state_reg == S_IDLE) && cfg_ok_reg, phase_reg < eff_den_reg, "phase accumulator reached the denominator")
    `FRCC_ASSERT_NEXT(a_bad_cfg_keeps_total, clk, rst_n, item_acc && !cfg_ok_reg, $stable(total_reg) && (state_reg == S_FINISH), "rejected item changed the running total")
    `FRCC_ASSERT_IMPLY(a_error_zero_counts, clk, rst_n, out_valid_reg && (out_status_reg == STATUS_BAD_ARG), (out_conv_reg == '0) && (out_need_reg == '0), "error beat carries nonzero counts")

endmodule

`default_nettype wire

// File: design/frcc_arith.sv
// Shared radix-2 arithmetic unit: restoring divider and shift-add multiplier.
// Retires one bit per step; depends on frcc_pkg for the command type.
`default_nettype none

module frcc_arith #(
    parameter int WORD_WIDTH  = 64,
    parameter int RATIO_WIDTH = 32
) (
    input  logic                              clk,
    input  frcc_pkg::arith_cmd_t              cmd,
    input  logic [RATIO_WIDTH-1:0]            divisor,
    input  logic [WORD_WIDTH-1:0]             ld_word,
    input  logic [WORD_WIDTH-1:0]             ld_upper,
    input  logic [RATIO_WIDTH-1:0]            ld_mplier,
    output logic [WORD_WIDTH-1:0]             quotient,
    output logic [RATIO_WIDTH-1:0]            remainder,
    output logic [WORD_WIDTH+RATIO_WIDTH-1:0] product
);
    import frcc_pkg::*;

    localparam int PW = WORD_WIDTH + RATIO_WIDTH;

    logic [WORD_WIDTH-1:0]  dvd_reg, dvd_next;
    logic [RATIO_WIDTH-1:0] rmd_reg, rmd_next;
    logic [PW-1:0]          prod_reg, prod_next;
    logic [WORD_WIDTH-1:0]  mcand_reg, mcand_next;

    logic [RATIO_WIDTH:0]   shifted;
    logic [RATIO_WIDTH:0]   trial;
    logic                   fits;
    logic [WORD_WIDTH:0]    addend;
    logic [WORD_WIDTH:0]    acc;

    // The divider shifts the dividend through the remainder one bit per step, while
    // the multiplier adds into the upper half and shifts the product right.
    always_comb
    begin
        shifted = {rmd_reg, dvd_reg[WORD_WIDTH-1]};
        trial   = shifted - {1'b0, divisor};
        fits    = (shifted >= {1'b0, divisor});
        addend  = prod_reg[0] ? {1'b0, mcand_reg} : '0;
        acc     = {1'b0, prod_reg[PW-1:RATIO_WIDTH]} + addend;

        dvd_next   = dvd_reg;
        rmd_next   = rmd_reg;
        prod_next  = prod_reg;
        mcand_next = mcand_reg;
        case (cmd)
            ARITH_LOAD_DIV:
            begin
                dvd_next = ld_word;
                rmd_next = ld_upper[RATIO_WIDTH-1:0];
            end
            ARITH_LOAD_MUL:
            begin
                mcand_next = ld_word;
                prod_next  = {ld_upper, ld_mplier};
            end
            ARITH_DIV_STEP:
            begin
                rmd_next = fits ? trial[RATIO_WIDTH-1:0] : shifted[RATIO_WIDTH-1:0];
                dvd_next = {dvd_reg[WORD_WIDTH-2:0], fits};
            end
            ARITH_MUL_STEP:
            begin
                prod_next = {acc, prod_reg[RATIO_WIDTH-1:1]};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        dvd_reg   <= dvd_next;
        rmd_reg   <= rmd_next;
        prod_reg  <= prod_next;
        mcand_reg <= mcand_next;
    end

    assign quotient  = dvd_reg;
    assign remainder = rmd_reg;
    assign product   = prod_reg;

endmodule

`default_nettype wire

// File: sim/fractional_clock_ratio_converter_tb.sv
// Self-checking testbench for the fractional clock ratio converter: random bursts of
// advance, query and reset items under many ratio settings, checked against a predictor.
// Depends on frcc_pkg, the channel interfaces and the converter top level.
`default_nettype none

module fractional_clock_ratio_converter_tb;

    import frcc_pkg::*;

    localparam int COUNT_W = 64;
    localparam int RATIO_W = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [RATIO_W-1:0] RATIO_MAX = '1;

    localparam logic [KIND_W-1:0]    KIND_UNDEFINED = KIND_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED     = CFG_IDX_W'(3);

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [COUNT_W-1:0] amount;
        logic               wait_idle;
    } tick_req_t;

    typedef struct packed {
        logic [COUNT_W-1:0]  converted;
        logic [COUNT_W-1:0]  needed;
        logic [COUNT_W-1:0]  total;
        logic [STATUS_W-1:0] status;
    } tick_result_t;

    logic clk = 1'b0;
    logic rst_n;

    frcc_cfg_if #(.RATIO_WIDTH(RATIO_W)) cfg_ch ();
    frcc_item_if #(.COUNT_WIDTH(COUNT_W)) item_ch ();
    frcc_result_if #(.COUNT_WIDTH(COUNT_W)) result_ch ();

    fractional_clock_ratio_converter #(
        .COUNT_WIDTH(COUNT_W),
        .RATIO_WIDTH(RATIO_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_ch),
        .item(item_ch),
        .result(result_ch)
    );

    logic [RATIO_W-1:0] ratio_num = '0;
    logic [RATIO_W-1:0] ratio_den = '0;
    logic [RATIO_W-1:0] ratio_phase = '0;
    logic [COUNT_W-1:0] phase_acc = '0;
    logic [COUNT_W-1:0] ticks_total = '0;

    tick_req_t    pending_items[$];
    tick_result_t expected_ticks[$];

    int  items_total = 0;
    int  items_checked = 0;
    bit  failed = 1'b0;

    int  burst_left;
    int  gap_left;
    int  beats_taken;
    int  holdoff_left;
    int  stall_mode;
    int  mode_left;
    logic [7:0] stall_pattern;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic bit active_ratio(output logic [COUNT_W-1:0] n, d, p);
        if (ratio_num == 0 && ratio_den == 0 && ratio_phase == 0)
        begin
            n = 1;
            d = 1;
            p = 0;
            return 1'b1;
        end
        n = ratio_num;
        d = ratio_den;
        p = ratio_phase;
        return !(ratio_num == 0 || ratio_den == 0 || ratio_phase >= ratio_den);
    endfunction

    function automatic tick_result_t convert_ticks(logic [KIND_W-1:0] kind,
                                                   logic [COUNT_W-1:0] amount);
        tick_result_t r;
        logic [COUNT_W-1:0] n, d, p, whole, rem, req;
        bit ok;
        r = '0;
        r.status = STATUS_OK;
        ok = active_ratio(n, d, p);
        if (!ok)
            r.status = STATUS_BAD_ARG;
        else
            case (kind)
                KIND_ADVANCE:
                begin
                    if (n == d)
                        r.converted = amount;
                    else
                    begin
                        whole = (amount / d) * n;
                        rem = (amount % d) * n + phase_acc;
                        r.converted = whole + rem / d;
                        phase_acc = rem % d;
                    end
                    ticks_total = ticks_total + r.converted;
                end
                KIND_QUERY:
                begin
                    if (amount == 0 || amount > COUNT_MAX / d)
                        r.status = STATUS_BAD_ARG;
                    else
                    begin
                        req = amount * d;
                        if (req <= phase_acc)
                            r.needed = 1;
                        else
                        begin
                            req = req - phase_acc;
                            r.needed = req / n;
                            if (req % n != 0)
                                r.needed = r.needed + 1;
                        end
                    end
                end
                KIND_RESET:
                begin
                    phase_acc = p;
                    ticks_total = '0;
                end
                default:
                    r.status = STATUS_BAD_ARG;
            endcase
        r.total = ticks_total;
        return r;
    endfunction

    function automatic void compare_field(string what, logic [COUNT_W-1:0] want,
                                          logic [COUNT_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
            failed = 1'b1;
        end
    endfunction

    function automatic logic [COUNT_W-1:0] random_amount();
        logic [COUNT_W-1:0] wide;
        wide = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1, 2: return wide % 1024;
            3, 4, 5: return wide;
            6, 7: return {32'd0, wide[31:0]};
            8: return COUNT_MAX - wide[9:0];
            default: return 64'd1 << wide[5:0];
        endcase
    endfunction

    function automatic logic [COUNT_W-1:0] query_amount(logic [COUNT_W-1:0] d);
        logic [COUNT_W-1:0] wide, lim;
        wide = {$urandom, $urandom};
        lim = COUNT_MAX / d;
        case ($urandom_range(0, 19))
            0: return '0;
            1: return (lim == COUNT_MAX) ? lim : lim + 1;
            2: return lim;
            3, 4, 5, 6, 7, 8, 9: return wide % 100 + 1;
            default: return wide % lim + 1;
        endcase
    endfunction

    task automatic queue_item(logic [KIND_W-1:0] kind, logic [COUNT_W-1:0] amount,
                              logic wait_idle);
        pending_items.push_back('{kind: kind, amount: amount, wait_idle: wait_idle});
        items_total++;
    endtask

    task automatic wait_drained();
        while (items_checked < items_total)
            @(posedge clk);
    endtask

    task automatic write_ratio_reg(logic [CFG_IDX_W-1:0] idx, logic [RATIO_W-1:0] value);
        logic [COUNT_W-1:0] n, d, p;
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_RATIO_NUMERATOR: ratio_num = value;
            CFG_RATIO_DENOMINATOR: ratio_den = value;
            CFG_START_PHASE: ratio_phase = value;
            default: ;
        endcase
        if (idx != CFG_UNUSED)
        begin
            phase_acc = active_ratio(n, d, p) ? p : '0;
            ticks_total = '0;
        end
    endtask

    task automatic program_ratio(logic [RATIO_W-1:0] n, logic [RATIO_W-1:0] d,
                                 logic [RATIO_W-1:0] p);
        wait_drained();
        write_ratio_reg(CFG_RATIO_NUMERATOR, n);
        write_ratio_reg(CFG_RATIO_DENOMINATOR, d);
        write_ratio_reg(CFG_START_PHASE, p);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic took;
        tick_req_t nxt;
        if (!rst_n)
        begin
            item_ch.valid <= 1'b0;
            item_ch.kind <= KIND_ADVANCE;
            item_ch.amount <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            took = item_ch.valid && item_ch.ready;
            if (took)
                expected_ticks.push_back(convert_ticks(item_ch.kind, item_ch.amount));
            if (!item_ch.valid || took)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    item_ch.valid <= 1'b0;
                end
                else if (pending_items.size() != 0 &&
                         !(pending_items[0].wait_idle && expected_ticks.size() != 0))
                begin
                    nxt = pending_items.pop_front();
                    item_ch.valid <= 1'b1;
                    item_ch.kind <= nxt.kind;
                    item_ch.amount <= nxt.amount;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        if ($urandom_range(0, 3) == 0)
                            gap_left = 0;
                        else if ($urandom_range(0, 15) == 0)
                            gap_left = $urandom_range(60, 120);
                        else
                            gap_left = $urandom_range(1, 20);
                    end
                    else
                        burst_left--;
                end
                else
                    item_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            beats_taken = 0;
            holdoff_left = 0;
            stall_mode = 0;
            mode_left = 0;
            stall_pattern = 8'b1011_0010;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                beats_taken++;
                if (beats_taken == 250 || beats_taken == 700)
                    holdoff_left = 700;
            end
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 300);
                stall_pattern = $urandom;
            end
            else
                mode_left--;
            stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
            if (holdoff_left != 0)
            begin
                holdoff_left--;
                result_ch.ready <= 1'b0;
            end
            else
                case (stall_mode)
                    0: result_ch.ready <= 1'b1;
                    1: result_ch.ready <= ($urandom_range(0, 3) != 0);
                    2: result_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: result_ch.ready <= stall_pattern[0];
                endcase
        end
    end

    always @(posedge clk)
    begin
        tick_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            items_checked++;
            if (expected_ticks.size() == 0)
            begin
                $display("%0t: unexpected beat: expected none, actual %0h %0h %0h %0h", $time,
                         result_ch.converted_ticks, result_ch.source_ticks_needed,
                         result_ch.total_delivered, result_ch.status);
                failed = 1'b1;
            end
            else
            begin
                want = expected_ticks.pop_front();
                compare_field("converted_ticks", want.converted, result_ch.converted_ticks);
                compare_field("source_ticks_needed", want.needed, result_ch.source_ticks_needed);
                compare_field("total_delivered", want.total, result_ch.total_delivered);
                compare_field("status", want.status, result_ch.status);
            end
        end
    end

    initial
    begin
        logic [RATIO_W-1:0] n, d, p;
        logic [COUNT_W-1:0] n64, d64, p64;
        logic [KIND_W-1:0]  kind;
        int                 pick;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_RATIO_NUMERATOR;
        cfg_ch.data <= '0;
        rst_n <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The reset configuration is the identity ratio.
        queue_item(KIND_ADVANCE, '0, 1'b0);
        queue_item(KIND_ADVANCE, COUNT_MAX, 1'b0);
        queue_item(KIND_ADVANCE, 64'd1, 1'b0);
        queue_item(KIND_QUERY, '0, 1'b0);
        queue_item(KIND_QUERY, 64'd1, 1'b0);
        queue_item(KIND_QUERY, COUNT_MAX, 1'b0);
        queue_item(KIND_RESET, 64'd77, 1'b0);
        queue_item(KIND_UNDEFINED, COUNT_MAX, 1'b0);

        program_ratio(32'd3, 32'd7, 32'd5);
        queue_item(KIND_ADVANCE, COUNT_MAX, 1'b0);
        queue_item(KIND_QUERY, 64'd1, 1'b0);
        queue_item(KIND_QUERY, COUNT_MAX / 7 + 1, 1'b0);
        queue_item(KIND_QUERY, COUNT_MAX / 7, 1'b0);
        queue_item(KIND_ADVANCE, 64'd6, 1'b0);

        // A write to the unused index must leave the phase and total alone.
        wait_drained();
        write_ratio_reg(CFG_UNUSED, RATIO_MAX);
        queue_item(KIND_ADVANCE, 64'd100, 1'b0);
        queue_item(KIND_RESET, '0, 1'b0);

        program_ratio(32'd5, 32'd5, 32'd4);
        queue_item(KIND_ADVANCE, COUNT_MAX, 1'b0);
        queue_item(KIND_QUERY, 64'd3, 1'b0);

        program_ratio(RATIO_MAX, 32'd1, 32'd0);
        queue_item(KIND_ADVANCE, COUNT_MAX, 1'b0);
        queue_item(KIND_QUERY, COUNT_MAX, 1'b0);

        program_ratio(32'd1, RATIO_MAX, RATIO_MAX - 1);
        queue_item(KIND_ADVANCE, COUNT_MAX, 1'b0);
        queue_item(KIND_QUERY, 64'd2, 1'b0);

        program_ratio(32'd0, 32'd9, 32'd0);
        queue_item(KIND_ADVANCE, 64'd5, 1'b0);
        queue_item(KIND_QUERY, 64'd1, 1'b0);

        program_ratio(32'd4, 32'd4, 32'd4);
        queue_item(KIND_RESET, '0, 1'b0);

        for (int ph = 0; ph < 14; ph++)
        begin
            pick = $urandom_range(0, 11);
            case (pick)
                0:
                begin
                    n = '0;
                    d = '0;
                    p = '0;
                end
                1:
                begin
                    n = '0;
                    d = $urandom;
                    p = '0;
                end
                2:
                begin
                    n = $urandom_range(1, 100);
                    d = $urandom_range(1, 1000);
                    p = d + $urandom_range(0, 5);
                end
                3:
                begin
                    n = $urandom_range(1, RATIO_MAX);
                    d = n;
                    p = $urandom % d;
                end
                4:
                begin
                    n = RATIO_MAX;
                    d = 32'd1;
                    p = '0;
                end
                5:
                begin
                    n = 32'd1;
                    d = RATIO_MAX;
                    p = $urandom % d;
                end
                6, 7:
                begin
                    n = $urandom_range(1, 16);
                    d = $urandom_range(1, 16);
                    p = $urandom_range(0, d - 1);
                end
                default:
                begin
                    n = $urandom_range(1, RATIO_MAX);
                    d = $urandom_range(1, RATIO_MAX);
                    p = $urandom % d;
                end
            endcase
            program_ratio(n, d, p);
            void'(active_ratio(n64, d64, p64));
            if (d64 == 0)
                d64 = 1;
            for (int i = 0; i < 75; i++)
            begin
                pick = $urandom_range(0, 19);
                if (pick <= 10)
                    kind = KIND_ADVANCE;
                else if (pick <= 16)
                    kind = KIND_QUERY;
                else if (pick <= 18)
                    kind = KIND_RESET;
                else
                    kind = KIND_UNDEFINED;
                queue_item(kind, (kind == KIND_QUERY) ? query_amount(d64) : random_amount(),
                           ($urandom_range(0, 39) == 0) || (ph == 2 && i == 10));
            end
        end

        wait_drained();
        repeat (200) @(posedge clk);
        if (failed || expected_ticks.size() != 0)
            $display("CHECK FAILED");
        else
            $display("CHECK OK");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
